// ===== sv/sse_pkg.sv =====
// Shared types, constants and state codes of the stack expression evaluator.
`default_nettype none

package sse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
	localparam int SYM_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [SYM_W-1:0]       sym_t;
	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [ADDR_W-1:0]      addr_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_UNDER = 2'd1;
	localparam status_t ST_DIVZ  = 2'd2;
	localparam status_t ST_OVER  = 2'd3;

	localparam sym_t CH_PLUS  = 8'h2B;
	localparam sym_t CH_MINUS = 8'h2D;
	localparam sym_t CH_MUL   = 8'h2A;
	localparam sym_t CH_DIV   = 8'h2F;
	localparam sym_t CH_ZERO  = 8'd48;
	localparam sym_t CH_NINE  = 8'd57;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP1,
		S_POP2,
		S_EXEC,
		S_DIV,
		S_WB,
		S_TOP_RD,
		S_TOP
	} state_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		logic   div_zero;
		value_t quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/sse_ifs.sv =====
// Valid/ready channel interfaces: symbol input, result output, mode register write.
`default_nettype none

interface sse_sym_if;
	logic                    valid;
	logic                    ready;
	logic [sse_pkg::SYM_W-1:0] symbol;
	logic                    last;

	modport source (output valid, symbol, last, input ready);
	modport sink   (input valid, symbol, last, output ready);
endinterface

interface sse_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sse_pkg::VALUE_WIDTH-1:0] value;
	logic [sse_pkg::STATUS_W-1:0]          status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface

interface sse_cfg_if;
	logic valid;
	logic ready;
	logic eval_order;

	modport source (output valid, eval_order, input ready);
	modport sink   (input valid, eval_order, output ready);
endinterface

`default_nettype wire

// ===== sv/sse_div.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module sse_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sse_pkg::div_req_t req,
	output sse_pkg::div_rsp_t      rsp
);

	localparam int W = sse_pkg::VALUE_WIDTH;

	logic                         busy_q;
	logic                         done_q;
	logic [sse_pkg::CNT_W-1:0]    cnt_q;
	sse_pkg::value_t              rem_q;
	sse_pkg::value_t              quo_q;
	sse_pkg::value_t              den_q;
	logic                         neg_q;
	logic                         divz_q;

	logic            a_neg;
	logic            b_neg;
	sse_pkg::value_t a_mag;
	sse_pkg::value_t b_mag;
	logic [W:0]      shift_rem;
	logic [W:0]      diff;
	logic            ge;

	always_comb begin
		a_neg     = req.dividend[W-1];
		b_neg     = req.divisor[W-1];
		a_mag     = a_neg ? (~req.dividend + 1'b1) : req.dividend;
		b_mag     = b_neg ? (~req.divisor + 1'b1) : req.divisor;
		shift_rem = {rem_q, quo_q[W-1]};
		diff      = shift_rem - {1'b0, den_q};
		ge        = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (b_mag == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= sse_pkg::CNT_W'(W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == sse_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= b_mag;
			divz_q <= (b_mag == '0);
			quo_q  <= (b_mag == '0) ? '0 : a_mag;
			neg_q  <= (b_mag == '0) ? 1'b0 : (a_neg ^ b_neg);
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shift_rem[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = divz_q;
	assign rsp.quot     = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

// ===== sv/stack_expression_evaluator.sv =====
// Top level: stack-based postfix/prefix expression evaluator over a RAM stack.
//
// Usage notes:
//  - symbols: one ASCII character per beat plus a last flag. Digits push their
//    value, + - * / pop two operands and push the result, anything else is
//    skipped. The beat with last set produces exactly one beat on results.
//  - results: top of stack (32-bit signed, 0 if the stack is empty) and status
//    (0 ok, 1 underflow, 2 divide by zero, 3 overflow; first error wins).
//    After the result is produced the stack and status are cleared.
//  - cfg: eval_order, 0 = postfix left to right, 1 = prefix fed right to left.
//    Write only while idle; ready is always high.
//  - One character is worked on at a time. Digits and ignored chars are taken
//    straight away; + - * wait for two registered reads of the stack RAM, / also
//    for the serial divider (which skips its iterations on divide by zero). A last
//    beat adds a top-of-stack read.
//  - Result sits in an output register; the block keeps taking symbols while
//    it waits. Only a second last beat stalls if results is still backed up.
//  - Reset (arst_n low) empties the stack, clears status, sets postfix mode
//    and drops any pending result. Stack RAM contents are not cleared.
`default_nettype none

module stack_expression_evaluator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sse_sym_if.sink    symbols,
	sse_res_if.source  results,
	sse_cfg_if.sink    cfg
);

	// control state
	sse_pkg::state_t  state_q;
	sse_pkg::state_t  state_nxt;
	sse_pkg::ptr_t    sp_q;
	sse_pkg::status_t err_q;
	logic             order_q;
	logic             out_valid_q;

	// payload registers
	sse_pkg::sym_t    sym_q;
	logic             last_q;
	sse_pkg::value_t  first_q;
	sse_pkg::value_t  res_q;
	sse_pkg::value_t  out_value_q;
	sse_pkg::status_t out_status_q;

	// stack RAM
	sse_pkg::value_t  stack_mem [sse_pkg::STACK_DEPTH];
	sse_pkg::value_t  rd_data_q;
	sse_pkg::addr_t   rd_addr;
	sse_pkg::addr_t   wr_addr;
	sse_pkg::value_t  wr_data;
	logic             mem_we;

	// divider
	sse_pkg::div_req_t div_req;
	sse_pkg::div_rsp_t div_rsp;

	logic             accept;
	logic             in_digit;
	logic             in_op;
	logic             out_free;
	logic             stack_full;
	sse_pkg::ptr_t    sp_dec1;
	sse_pkg::ptr_t    sp_dec2;
	sse_pkg::value_t  opnd_first;
	sse_pkg::value_t  opnd_second;
	sse_pkg::value_t  lhs;
	sse_pkg::value_t  rhs;
	sse_pkg::value_t  alu_res;

	sse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		accept     = symbols.valid && symbols.ready;
		in_digit   = (symbols.symbol >= sse_pkg::CH_ZERO) && (symbols.symbol <= sse_pkg::CH_NINE);
		in_op      = (symbols.symbol == sse_pkg::CH_PLUS) || (symbols.symbol == sse_pkg::CH_MINUS)
		          || (symbols.symbol == sse_pkg::CH_MUL)  || (symbols.symbol == sse_pkg::CH_DIV);
		out_free   = !out_valid_q || results.ready;
		stack_full = (sp_q == sse_pkg::PTR_W'(sse_pkg::STACK_DEPTH));
		sp_dec1    = sp_q - sse_pkg::PTR_W'(1);
		sp_dec2    = sp_q - sse_pkg::PTR_W'(2);
	end

	// operand select and ALU for + - *; missing operands read as zero
	always_comb begin
		opnd_first  = first_q;
		opnd_second = (sp_q >= sse_pkg::PTR_W'(2)) ? rd_data_q : '0;
		// postfix: second pop is the left operand; prefix: the first pop is
		lhs = order_q ? opnd_first : opnd_second;
		rhs = order_q ? opnd_second : opnd_first;
		case (sym_q)
			sse_pkg::CH_PLUS:  alu_res = lhs + rhs;
			sse_pkg::CH_MINUS: alu_res = lhs - rhs;
			sse_pkg::CH_MUL:   alu_res = lhs * rhs;
			default:           alu_res = '0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sse_pkg::S_IDLE: begin
				if (accept) begin
					if (in_op) state_nxt = sse_pkg::S_POP1;
					else if (symbols.last) state_nxt = sse_pkg::S_TOP_RD;
				end
			end
			sse_pkg::S_POP1: state_nxt = sse_pkg::S_POP2;
			sse_pkg::S_POP2: state_nxt = sse_pkg::S_EXEC;
			sse_pkg::S_EXEC: begin
				state_nxt = (sym_q == sse_pkg::CH_DIV) ? sse_pkg::S_DIV : sse_pkg::S_WB;
			end
			sse_pkg::S_DIV: begin
				if (div_rsp.done) state_nxt = sse_pkg::S_WB;
			end
			sse_pkg::S_WB: state_nxt = last_q ? sse_pkg::S_TOP_RD : sse_pkg::S_IDLE;
			sse_pkg::S_TOP_RD: state_nxt = sse_pkg::S_TOP;
			sse_pkg::S_TOP: begin
				if (out_free) state_nxt = sse_pkg::S_IDLE;
			end
			default: state_nxt = sse_pkg::S_IDLE;
		endcase
	end

	// state outputs: handshake, RAM port, divider start
	always_comb begin
		symbols.ready    = 1'b0;
		mem_we           = 1'b0;
		wr_addr          = sp_q[sse_pkg::ADDR_W-1:0];
		wr_data          = res_q;
		rd_addr          = sp_dec1[sse_pkg::ADDR_W-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = lhs;
		div_req.divisor  = rhs;
		case (state_q)
			sse_pkg::S_IDLE: begin
				symbols.ready = 1'b1;
				// digit push goes straight into the RAM on the accept beat
				mem_we  = accept && in_digit && !stack_full;
				wr_data = sse_pkg::VALUE_WIDTH'(symbols.symbol - sse_pkg::CH_ZERO);
			end
			sse_pkg::S_POP2: rd_addr = sp_dec2[sse_pkg::ADDR_W-1:0];
			sse_pkg::S_EXEC: div_req.start = (sym_q == sse_pkg::CH_DIV);
			sse_pkg::S_WB:   mem_we = 1'b1;
			default: ;
		endcase
	end

	// stack RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[wr_addr] <= wr_data;
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sse_pkg::S_IDLE;
			sp_q        <= '0;
			err_q       <= sse_pkg::ST_OK;
			order_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg.valid) order_q <= cfg.eval_order;
			if (results.ready) out_valid_q <= 1'b0;
			case (state_q)
				sse_pkg::S_IDLE: begin
					if (accept && in_digit) begin
						if (stack_full) begin
							if (err_q == sse_pkg::ST_OK) err_q <= sse_pkg::ST_OVER;
						end else begin
							sp_q <= sp_q + sse_pkg::PTR_W'(1);
						end
					end
				end
				sse_pkg::S_EXEC: begin
					// both pops happen here; short stack means underflow
					if (sp_q < sse_pkg::PTR_W'(2)) begin
						sp_q <= '0;
						if (err_q == sse_pkg::ST_OK) err_q <= sse_pkg::ST_UNDER;
					end else begin
						sp_q <= sp_dec2;
					end
				end
				sse_pkg::S_DIV: begin
					if (div_rsp.done && div_rsp.div_zero && err_q == sse_pkg::ST_OK)
						err_q <= sse_pkg::ST_DIVZ;
				end
				sse_pkg::S_WB: sp_q <= sp_q + sse_pkg::PTR_W'(1);
				sse_pkg::S_TOP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sp_q        <= '0;
						err_q       <= sse_pkg::ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= symbols.symbol;
			last_q <= symbols.last;
		end
		if (state_q == sse_pkg::S_POP2)
			first_q <= (sp_q != '0) ? rd_data_q : '0;
		if (state_q == sse_pkg::S_EXEC)
			res_q <= alu_res;
		if (state_q == sse_pkg::S_DIV && div_rsp.done)
			res_q <= div_rsp.quot;
		if (state_q == sse_pkg::S_TOP && out_free) begin
			out_value_q  <= (sp_q != '0) ? rd_data_q : '0;
			out_status_q <= err_q;
		end
	end

	assign cfg.ready      = 1'b1;
	assign results.valid  = out_valid_q;
	assign results.value  = $signed(out_value_q);
	assign results.status = out_status_q;

endmodule

`default_nettype wire
